@@ hw/rtl/sshh_pkg.sv @@
// sshh_pkg: shared types and constants of the strip hit histogrammer
// no dependencies
`default_nettype none
package sshh_pkg;

  localparam int unsigned Detectors = 4;
  localparam int unsigned Sides = 8;
  localparam int unsigned SideCountMax = 127;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_END  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_PARTICLE  = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIT,
    ST_CLOSE_DET,
    ST_CLOSE_RD,
    ST_CLOSE_BIN,
    ST_CLOSE_WR,
    ST_CLOSE_DONE,
    ST_READ,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_step;   // write zero at the sweep address, advance it
    logic latch_in;     // capture the accepted word
    logic do_hit;       // update counts and buffer
    logic open_event;   // mark event open with latched id
    logic start_close;  // reset detector and entry pointers
    logic buf_rd;       // read buffer entry
    logic bin_rd;       // read histogram bin of buffered strip
    logic bin_wr;       // write incremented bin, advance entry
    logic next_det;     // advance detector, entry pointer to zero
    logic finish_close; // clear counts, fills, event flag
    logic read_bin;     // read bin for an output word
    logic load_out;     // move read data to output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic event_open;
    logic id_differs;
    logic det_active;   // current detector has hits on one side only
    logic entry_left;   // more buffered entries for current detector
    logic last_det;
  } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/sshh_datapath.sv @@
// sshh_datapath: counts, strip buffers, histogram memory and output register
// depends on sshh_pkg
`default_nettype none
module sshh_datapath #(
  parameter int unsigned STRIP_COUNT = 1024,
  parameter int unsigned MAX_HITS_PER_EVENT = 64,
  parameter int unsigned BIN_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sshh_pkg::cmd_t       cmd_i,
  output sshh_pkg::stat_t           stat_o,
  input  wire logic [15:0]          threshold_i,
  input  wire logic [7:0]           particle_code_i,
  input  wire logic [31:0]          event_id_i,
  input  wire logic [2:0]           side_id_i,
  input  wire logic [9:0]           strip_i,
  input  wire logic [15:0]          energy_i,
  input  wire logic [7:0]           particle_i,
  input  wire logic [1:0]           read_detector_i,
  output logic [31:0]               bin_count_o
);

  localparam int unsigned BinAw = $clog2(STRIP_COUNT);
  localparam int unsigned HistAw = BinAw + 2;
  localparam int unsigned HistDepth = 4 << BinAw;
  localparam int unsigned EntAw = $clog2(MAX_HITS_PER_EVENT);
  localparam int unsigned FillW = $clog2(MAX_HITS_PER_EVENT + 1);
  localparam int unsigned BufDepth = 4 << EntAw;
  localparam logic [BIN_WIDTH-1:0] BinMax = '1;

  logic [9:0]           buf_mem [BufDepth];
  logic [BIN_WIDTH-1:0] hist_mem [HistDepth];

  logic [31:0] ev_q, cur_ev_q;
  logic [2:0]  side_q;
  logic [9:0]  strip_q;
  logic [15:0] energy_q;
  logic [7:0]  particle_q;
  logic [1:0]  rdet_q;
  logic        open_q;
  logic [6:0]  cnt_q [8];
  logic [FillW-1:0] fill_q [4];
  logic [HistAw:0]  clr_q;
  logic [1:0]       det_q;
  logic [FillW-1:0] ent_q;
  logic [9:0]       bstrip_q;
  logic [BIN_WIDTH-1:0] bin_q;
  logic [HistAw-1:0]    waddr_q;
  logic                 inrange_q;
  logic [31:0]          out_q;

  logic       counts;
  logic [6:0] own_new;
  logic [6:0] opp_cnt;
  logic [1:0] hdet;
  logic [2:0] opp_side;

  assign hdet = side_q[2:1];
  assign opp_side = side_q ^ 3'd1;
  assign counts = (energy_q > threshold_i) && (particle_q == particle_code_i);
  assign own_new = (counts && cnt_q[side_q] != 7'(sshh_pkg::SideCountMax)) ?
                   cnt_q[side_q] + 7'd1 : cnt_q[side_q];
  assign opp_cnt = cnt_q[opp_side];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      cur_ev_q <= '0;
      clr_q <= '0;
      det_q <= '0;
      ent_q <= '0;
      for (int i = 0; i < 8; i++) cnt_q[i] <= '0;
      for (int i = 0; i < 4; i++) fill_q[i] <= '0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.open_event) begin
        open_q <= 1'b1;
        cur_ev_q <= ev_q;
      end
      if (cmd_i.do_hit) begin
        // opposite count read from the current registers; sides differ so no hazard
        cnt_q[side_q] <= own_new;
        if (opp_cnt == '0 && fill_q[hdet] < FillW'(MAX_HITS_PER_EVENT)) begin
          fill_q[hdet] <= fill_q[hdet] + 1'b1;
        end
      end
      if (cmd_i.start_close) begin
        det_q <= '0;
        ent_q <= '0;
      end
      if (cmd_i.bin_wr) ent_q <= ent_q + 1'b1;
      if (cmd_i.next_det) begin
        det_q <= det_q + 2'd1;
        ent_q <= '0;
      end
      if (cmd_i.finish_close) begin
        open_q <= 1'b0;
        for (int i = 0; i < 8; i++) cnt_q[i] <= '0;
        for (int i = 0; i < 4; i++) fill_q[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      ev_q <= event_id_i;
      side_q <= side_id_i;
      strip_q <= strip_i;
      energy_q <= energy_i;
      particle_q <= particle_i;
      rdet_q <= read_detector_i;
    end
    if (cmd_i.do_hit && opp_cnt == '0 && fill_q[hdet] < FillW'(MAX_HITS_PER_EVENT)) begin
      buf_mem[{hdet, fill_q[hdet][EntAw-1:0]}] <= strip_q;
    end
    if (cmd_i.buf_rd) bstrip_q <= buf_mem[{det_q, ent_q[EntAw-1:0]}];
    if (cmd_i.bin_rd) begin
      bin_q <= hist_mem[{det_q, BinAw'(bstrip_q)}];
      waddr_q <= {det_q, BinAw'(bstrip_q)};
      inrange_q <= 32'(bstrip_q) < STRIP_COUNT;
    end
    if (cmd_i.read_bin) begin
      bin_q <= hist_mem[{rdet_q, BinAw'(strip_q)}];
      inrange_q <= 32'(strip_q) < STRIP_COUNT;
    end
    if (cmd_i.clear_step) hist_mem[clr_q[HistAw-1:0]] <= '0;
    else if (cmd_i.bin_wr && inrange_q && bin_q != BinMax) begin
      hist_mem[waddr_q] <= bin_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      if (!inrange_q) out_q <= '0;
      else if (BIN_WIDTH > 32 && (bin_q >> 32) != '0) out_q <= '1;
      else out_q <= 32'(bin_q);
    end
  end

  assign bin_count_o = out_q;
  assign stat_o.clear_done = clr_q[HistAw];
  assign stat_o.event_open = open_q;
  assign stat_o.id_differs = ev_q != cur_ev_q;
  assign stat_o.det_active = (cnt_q[{det_q, 1'b0}] != '0) != (cnt_q[{det_q, 1'b1}] != '0);
  assign stat_o.entry_left = ent_q < fill_q[det_q];
  assign stat_o.last_det = det_q == 2'd3;

endmodule
`default_nettype wire

@@ hw/rtl/sshh_ctrl.sv @@
// sshh_ctrl: sequencer for hits, event close walk, reads and memory clear
// depends on sshh_pkg
`default_nettype none
module sshh_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      kind_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire sshh_pkg::stat_t stat_i,
  output sshh_pkg::cmd_t       cmd_o
);

  sshh_pkg::state_e state_q, state_d;
  sshh_pkg::kind_e  kind_q;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_stall_o = state_q != sshh_pkg::ST_IDLE;
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sshh_pkg::ST_CLEAR;
      kind_q <= sshh_pkg::KIND_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) kind_q <= sshh_pkg::kind_e'(kind_i);
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      sshh_pkg::ST_CLEAR: begin
        if (stat_i.clear_done) state_d = sshh_pkg::ST_IDLE;
        else cmd_o.clear_step = 1'b1;
      end
      sshh_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.latch_in = 1'b1;
          unique case (sshh_pkg::kind_e'(kind_i))
            sshh_pkg::KIND_HIT:  state_d = sshh_pkg::ST_HIT;
            sshh_pkg::KIND_END:  state_d = sshh_pkg::ST_HIT;
            sshh_pkg::KIND_READ: state_d = sshh_pkg::ST_READ;
            default:             state_d = sshh_pkg::ST_IDLE;
          endcase
        end
      end
      sshh_pkg::ST_HIT: begin
        // decide whether the event closes first
        if (stat_i.event_open && (kind_q == sshh_pkg::KIND_END || stat_i.id_differs)) begin
          cmd_o.start_close = 1'b1;
          state_d = sshh_pkg::ST_CLOSE_DET;
        end else if (kind_q == sshh_pkg::KIND_HIT) begin
          cmd_o.do_hit = 1'b1;
          cmd_o.open_event = 1'b1;
          state_d = sshh_pkg::ST_IDLE;
        end else begin
          state_d = sshh_pkg::ST_IDLE;
        end
      end
      sshh_pkg::ST_CLOSE_DET: begin
        if (stat_i.det_active && stat_i.entry_left) begin
          cmd_o.buf_rd = 1'b1;
          state_d = sshh_pkg::ST_CLOSE_RD;
        end else if (stat_i.last_det) begin
          state_d = sshh_pkg::ST_CLOSE_DONE;
        end else begin
          cmd_o.next_det = 1'b1;
        end
      end
      sshh_pkg::ST_CLOSE_RD: begin
        cmd_o.bin_rd = 1'b1;
        state_d = sshh_pkg::ST_CLOSE_BIN;
      end
      sshh_pkg::ST_CLOSE_BIN: begin
        cmd_o.bin_wr = 1'b1;
        state_d = sshh_pkg::ST_CLOSE_DET;
      end
      sshh_pkg::ST_CLOSE_WR: begin
        state_d = sshh_pkg::ST_CLOSE_DET;
      end
      sshh_pkg::ST_CLOSE_DONE: begin
        cmd_o.finish_close = 1'b1;
        state_d = sshh_pkg::ST_HIT;
      end
      sshh_pkg::ST_READ: begin
        cmd_o.read_bin = 1'b1;
        state_d = sshh_pkg::ST_OUT;
      end
      sshh_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = sshh_pkg::ST_IDLE;
        end
      end
      default: state_d = sshh_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/single_side_strip_hit_histogrammer_core.sv @@
// single_side_strip_hit_histogrammer_core: top level, config registers,
// controller and datapath; depends on sshh_pkg, sshh_ctrl, sshh_datapath
//
// channel | direction | handshake            | fields
// in      | input     | in_valid_i/in_stall_o | kind, event_id, side_id, strip,
//         |           |                       | energy, particle, read_detector
// out     | output    | out_valid_o/out_stall_i | bin_count
// cfg     | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// a hit passes ST_HIT, a read ST_READ and ST_OUT, held while the output waits
// an event close is a single port walk over buffer and histogram memory, with
// ST_CLOSE_RD and ST_CLOSE_BIN per buffered strip of an active detector
// after reset the histogram memory is swept one bin a cycle while input is
// stalled; the output register lets a read finish
`default_nettype none
module single_side_strip_hit_histogrammer_core #(
  parameter int unsigned STRIP_COUNT = 1024,
  parameter int unsigned MAX_HITS_PER_EVENT = 64,
  parameter int unsigned BIN_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] event_id_i,
  input  wire logic [2:0]  side_id_i,
  input  wire logic [9:0]  strip_i,
  input  wire logic [15:0] energy_i,
  input  wire logic [7:0]  particle_i,
  input  wire logic [1:0]  read_detector_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      bin_count_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] thr_q;
  logic [7:0]  pcode_q;
  sshh_pkg::cmd_t  cmd;
  sshh_pkg::stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd100;
      pcode_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == sshh_pkg::CFG_THRESHOLD) thr_q <= cfg_data_i;
      else if (cfg_index_i == sshh_pkg::CFG_PARTICLE) pcode_q <= cfg_data_i[7:0];
    end
  end

  sshh_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .kind_i, .in_stall_o,
    .out_valid_o, .out_stall_i, .stat_i(stat), .cmd_o(cmd)
  );

  sshh_datapath #(
    .STRIP_COUNT(STRIP_COUNT), .MAX_HITS_PER_EVENT(MAX_HITS_PER_EVENT),
    .BIN_WIDTH(BIN_WIDTH)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .threshold_i(thr_q),
    .particle_code_i(pcode_q), .event_id_i, .side_id_i, .strip_i, .energy_i,
    .particle_i, .read_detector_i, .bin_count_o
  );

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.clear_done |-> in_stall_o) else $error("input taken during clear");
  a_out_only_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out)) else $error("spurious output");
  a_no_hit_while_closing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_hit |-> !cmd.bin_wr && !cmd.clear_step) else $error("hit during walk");

endmodule
`default_nettype wire
